### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the waypoint picker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define NWTP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define NWTP_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nwtp_pkg.sv
// ----------------------------------------------------------------------------
// nwtp_pkg
// Commands, register indexes and cell control types of the waypoint picker.
// ----------------------------------------------------------------------------
package nwtp_pkg;

  // Commands carried in the input tuser.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_NEXT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_Z = 2'd2;

  // Slot select width, wide enough for the deepest supported table (64).
  localparam int unsigned SEL_W = 6;

  // Latency of the distance pipeline in cycles.
  localparam int unsigned DIST_LAT = 3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [SEL_W-1:0] sel;
  } cell_ctrl_t;

endpackage

### rtl/nwtp_cell.sv
// ----------------------------------------------------------------------------
// nwtp_cell
// One waypoint slot of the table ring: loads, rotates or closes a gap.
// ----------------------------------------------------------------------------
module nwtp_cell #(
  parameter int IDX = 0,
  parameter int CW  = 16
) (
  input  logic                 clk,
  input  nwtp_pkg::cell_ctrl_t ctrl,
  input  logic [3*CW-1:0]      load_pt,
  input  logic [3*CW-1:0]      nbr_pt,
  output logic [3*CW-1:0]      pt
);
  import nwtp_pkg::*;

  logic [3*CW-1:0] pt_r;
  logic [3*CW-1:0] pt_nxt;

  always_comb begin
    pt_nxt = pt_r;
    case (ctrl.op)
      CELL_LOAD: begin
        if (ctrl.sel == SEL_W'(IDX)) begin
          pt_nxt = load_pt;
        end
      end
      CELL_ROTATE: begin
        pt_nxt = nbr_pt;
      end
      CELL_REMOVE: begin
        // Slots at and above the removed one take their upper neighbor.
        if (ctrl.sel <= SEL_W'(IDX)) begin
          pt_nxt = nbr_pt;
        end
      end
      default: begin
        pt_nxt = pt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt = pt_r;

endmodule

### rtl/nwtp_dist.sv
// ----------------------------------------------------------------------------
// nwtp_dist
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module nwtp_dist #(
  parameter int CW = 16,
  parameter int IW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [IW-1:0]     in_idx,
  input  logic [3*CW-1:0]   in_pt,
  input  logic [3*CW-1:0]   pos,
  output logic              out_vld,
  output logic [IW-1:0]     out_idx,
  output logic [3*CW-1:0]   out_pt,
  output logic [2*CW+1:0]   out_dist
);
  import nwtp_pkg::*;

  localparam int DW = 2 * CW + 2;

  logic [DIST_LAT-1:0] vld_r;
  logic [IW-1:0]       idx1_r, idx2_r, idx3_r;
  logic [3*CW-1:0]     pt1_r, pt2_r, pt3_r;
  logic [CW-1:0]       abs_nxt [3];
  logic [CW-1:0]       abs_r   [3];
  logic [2*CW-1:0]     sq_r    [3];
  logic [DW-1:0]       sum_r;

  // Each difference is one bit wider than a coordinate, so it is exact.
  always_comb begin
    logic signed [CW:0] a;
    logic signed [CW:0] b;
    logic signed [CW:0] d;
    for (int c = 0; c < 3; c++) begin
      a = {in_pt[c*CW+CW-1], in_pt[c*CW +: CW]};
      b = {pos[c*CW+CW-1], pos[c*CW +: CW]};
      d = a - b;
      abs_nxt[c] = d[CW] ? CW'(-d) : d[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIST_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= in_idx;
    pt1_r  <= in_pt;
    for (int c = 0; c < 3; c++) begin
      abs_r[c] <= abs_nxt[c];
      sq_r[c]  <= abs_r[c] * abs_r[c];
    end
    idx2_r <= idx1_r;
    pt2_r  <= pt1_r;
    sum_r  <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
    idx3_r <= idx2_r;
    pt3_r  <= pt2_r;
  end

  assign out_vld  = vld_r[DIST_LAT-1];
  assign out_idx  = idx3_r;
  assign out_pt   = pt3_r;
  assign out_dist = sum_r;

endmodule

### rtl/nearest_waypoint_tour_picker.sv
// ----------------------------------------------------------------------------
// nearest_waypoint_tour_picker
// Waypoint table that hands out the stored point nearest the current position.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH waypoints in a ring of slot cells, packed
// in load order. Each input beat carries a command in tuser: load stores the
// beat's point in the next free slot (status is set and nothing changes when
// the table is full), clear empties the table, and next returns the stored
// point nearest the beat's position by squared distance, ties to the earliest
// loaded, removes it and raises the mission flag. A next on an empty table
// returns the base position from the configuration registers with is_base set
// and drops the mission flag. Every input beat yields exactly one output beat.
// Load, clear, an empty next and unused commands pass through the post state
// back to idle. A next on a non-empty table rotates the ring once through all
// TABLE_DEPTH slots, feeding one occupied slot per cycle into a single
// three-stage distance pipeline; then the pipeline drains, the remove state
// closes the gap left by the chosen slot and the post state posts the result.
// The output register decouples the result from the input side, so an input
// beat is taken while an earlier result still waits for out_tready.
// ----------------------------------------------------------------------------
module nearest_waypoint_tour_picker #(
  parameter int TABLE_DEPTH = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [nwtp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes.
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // tuser: cmd.
  input  logic [1:0]                        in_tuser,
  // Output stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: dest_x, dest_y, dest_z from bit 0 up, zero padded to bytes.
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // tuser: is_base, mission_active, status from bit 0 up.
  output logic [2:0]                        out_tuser
);
  import nwtp_pkg::*;

  localparam int CW          = COORD_WIDTH;
  localparam int PT_W        = 3 * CW;
  localparam int IN_TDATA_W  = ((PT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PT_W + 7) / 8) * 8;
  localparam int IW          = $clog2(TABLE_DEPTH);
  localparam int CNTW        = $clog2(TABLE_DEPTH + 1);
  localparam int DW          = 2 * CW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_REMOVE,
    S_POST
  } state_t;

  // Control and status registers.
  state_t            state_r,      state_nxt;
  logic [CNTW-1:0]   cnt_r,        cnt_nxt;
  logic              active_r,     active_nxt;
  logic [PT_W-1:0]   base_r,       base_nxt;
  logic [IW-1:0]     k_r,          k_nxt;
  logic [1:0]        drain_r,      drain_nxt;
  logic              have_best_r,  have_best_nxt;
  logic              out_valid_r,  out_valid_nxt;
  // Payload registers.
  logic [PT_W-1:0]   pos_r,        pos_nxt;
  logic [DW-1:0]     best_dist_r,  best_dist_nxt;
  logic [IW-1:0]     best_idx_r,   best_idx_nxt;
  logic [PT_W-1:0]   best_pt_r,    best_pt_nxt;
  logic [PT_W-1:0]   res_pt_r,     res_pt_nxt;
  logic [2:0]        res_flags_r,  res_flags_nxt;
  logic [PT_W-1:0]   out_pt_r,     out_pt_nxt;
  logic [2:0]        out_flags_r,  out_flags_nxt;

  cell_ctrl_t        cell_ctrl;
  logic [PT_W-1:0]   cell_pt [TABLE_DEPTH];
  logic [PT_W-1:0]   in_pt;
  logic              in_acc;

  logic              dist_in_vld;
  logic              dist_vld;
  logic [IW-1:0]     dist_idx;
  logic [PT_W-1:0]   dist_pt;
  logic [DW-1:0]     dist_val;

  assign in_pt     = in_tdata[PT_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Slot 0 of the ring feeds the distance pipeline while the ring rotates.
  assign dist_in_vld = (state_r == S_SCAN) && (CNTW'(k_r) < cnt_r);

  // Table ring: each cell's neighbor is the next slot, the top wraps to slot 0.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % TABLE_DEPTH;
    nwtp_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .load_pt (in_pt),
      .nbr_pt  (cell_pt[NXT]),
      .pt      (cell_pt[i])
    );
  end

  nwtp_dist #(
    .CW (CW),
    .IW (IW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (dist_in_vld),
    .in_idx   (k_r),
    .in_pt    (cell_pt[0]),
    .pos      (pos_r),
    .out_vld  (dist_vld),
    .out_idx  (dist_idx),
    .out_pt   (dist_pt),
    .out_dist (dist_val)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    drain_nxt     = drain_r;
    have_best_nxt = have_best_r;
    pos_nxt       = pos_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    best_pt_nxt   = best_pt_r;
    res_pt_nxt    = res_pt_r;
    res_flags_nxt = res_flags_r;
    out_pt_nxt    = out_pt_r;
    out_flags_nxt = out_flags_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.sel = '0;

    // Base position registers; the user writes them only while idle.
    if (cfg_we) begin
      case (cfg_addr)
        CFG_BASE_X: base_nxt[0*CW +: CW] = cfg_wdata;
        CFG_BASE_Y: base_nxt[1*CW +: CW] = cfg_wdata;
        CFG_BASE_Z: base_nxt[2*CW +: CW] = cfg_wdata;
        default:    base_nxt = base_r;
      endcase
    end

    // Keep the first strictly smaller distance, so ties stay with the
    // earliest loaded slot.
    if (dist_vld && (!have_best_r || (dist_val < best_dist_r))) begin
      have_best_nxt = 1'b1;
      best_dist_nxt = dist_val;
      best_idx_nxt  = dist_idx;
      best_pt_nxt   = dist_pt;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_pt_nxt    = '0;
          res_flags_nxt = {1'b0, active_r, 1'b0};
          state_nxt     = S_POST;
          case (in_tuser)
            CMD_LOAD: begin
              if (cnt_r < CNTW'(TABLE_DEPTH)) begin
                cell_ctrl.op  = CELL_LOAD;
                cell_ctrl.sel = SEL_W'(cnt_r);
                cnt_nxt       = cnt_r + CNTW'(1);
              end else begin
                res_flags_nxt = {1'b1, active_r, 1'b0};
              end
            end
            CMD_NEXT: begin
              if (cnt_r == '0) begin
                res_pt_nxt    = base_r;
                res_flags_nxt = {1'b0, 1'b0, 1'b1};
                active_nxt    = 1'b0;
              end else begin
                pos_nxt       = in_pt;
                k_nxt         = '0;
                have_best_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      S_SCAN: begin
        cell_ctrl.op = CELL_ROTATE;
        k_nxt        = k_r + IW'(1);
        if (k_r == IW'(TABLE_DEPTH - 1)) begin
          drain_nxt = 2'(DIST_LAT - 1);
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r - 2'd1;
        if (drain_r == '0) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cell_ctrl.op  = CELL_REMOVE;
        cell_ctrl.sel = SEL_W'(best_idx_r);
        cnt_nxt       = cnt_r - CNTW'(1);
        active_nxt    = 1'b1;
        res_pt_nxt    = best_pt_r;
        res_flags_nxt = {1'b0, 1'b1, 1'b0};
        state_nxt     = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pt_nxt    = res_pt_r;
          out_flags_nxt = res_flags_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      base_r      <= '0;
      k_r         <= '0;
      drain_r     <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      base_r      <= base_nxt;
      k_r         <= k_nxt;
      drain_r     <= drain_nxt;
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pt_r   <= best_pt_nxt;
    res_pt_r    <= res_pt_nxt;
    res_flags_r <= res_flags_nxt;
    out_pt_r    <= out_pt_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_pt_r);
  assign out_tuser  = out_flags_r;

endmodule

### rtl/nwtp_checker.sv
// ----------------------------------------------------------------------------
// nwtp_checker
// Port-level checks of the waypoint picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nwtp_checker #(
  parameter int IN_TDATA_W  = 48,
  parameter int OUT_TDATA_W = 48
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]             out_tuser
);

  // A stalled result beat keeps its data.
  `NWTP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "out beat changed while stalled")

  // Returning to base always ends the mission.
  `NWTP_ASSERT(a_base_ends_mission, clk, rst_n, out_tvalid && out_tuser[0] |-> !out_tuser[1], "base returned with mission active")

  // A dropped load carries no destination.
  `NWTP_ASSERT(a_drop_is_empty, clk, rst_n, out_tvalid && out_tuser[2] |-> out_tdata == '0 && !out_tuser[0], "dropped load with destination")

  // Reset leaves no result beat pending.
  `NWTP_ASSERT_ANY(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "out beat valid after reset")

endmodule

bind nearest_waypoint_tour_picker nwtp_checker #(
  .IN_TDATA_W  (IN_TDATA_W),
  .OUT_TDATA_W (OUT_TDATA_W)
) u_nwtp_checker (.*);
